@@ sv/hbp_pkg.sv @@
package hbp_pkg;

    localparam int CODE_W  = 32;
    localparam int LEN_W   = 6;
    localparam int BYTE_W  = 8;
    localparam int PCNT_W  = 3;
    localparam int TOTAL_W = 48;
    localparam int ACC_W   = CODE_W + BYTE_W;
    localparam int CNT_W   = 6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [1:0] FUNC_LOAD   = 2'd0;
    localparam logic [1:0] FUNC_ENCODE = 2'd1;
    localparam logic [1:0] FUNC_FLUSH  = 2'd2;

    // one code table entry
    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } hbp_entry_t;

    // one queued operation for the packer: code is left aligned
    typedef struct packed {
        logic              flush;
        logic [CODE_W-1:0] code_al;
        logic [LEN_W-1:0]  len;
    } hbp_op_t;

endpackage

@@ sv/hbp_ram.sv @@
module hbp_ram #(
    parameter int WIDTH = 38,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/hbp_fifo.sv @@
module hbp_fifo import hbp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  hbp_op_t           op_in,
    input  logic              pop,
    output hbp_op_t           op_out,
    output logic              not_empty,
    output logic [QCNT_W-1:0] count
);

    hbp_op_t           entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= op_in;
        end
    end

    assign op_out    = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

endmodule

@@ sv/hbp_front.sv @@
module hbp_front import hbp_pkg::*; #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOLS      = 256,
    localparam int ADDR_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_func,
    input  logic [7:0]        s_symbol,
    input  logic [CODE_W-1:0] s_code_bits,
    input  logic [LEN_W-1:0]  s_code_length,
    input  logic [QCNT_W-1:0] q_count,
    output logic              q_push,
    output hbp_op_t           q_op,
    output logic              ram_we,
    output logic [ADDR_W-1:0] ram_addr,
    output hbp_entry_t        ram_wdata,
    input  hbp_entry_t        ram_rdata
);

    localparam int CODE_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    logic              accept;
    logic              in_range;
    logic [LEN_W-1:0]  len_cl;
    logic [CODE_W:0]   one_sh;
    logic [CODE_W-1:0] len_mask;
    logic              s1_valid_reg, s1_valid_next;
    logic              s1_flush_reg;

    // admit only while the queue is sure to hold what the lookup stage pushes
    assign s_ready = ({1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid_reg})
                     < (QCNT_W + 1)'(QUEUE_DEPTH);
    assign accept   = s_valid && s_ready;
    assign in_range = ({1'b0, s_symbol} < 9'(SYMBOLS));

    assign len_cl   = (s_code_length > LEN_W'(CODE_LIMIT)) ? LEN_W'(CODE_LIMIT)
                                                           : s_code_length;
    assign one_sh   = (CODE_W + 1)'(1) << len_cl;
    assign len_mask = one_sh[CODE_W-1:0] - 1'b1;

    assign ram_we         = accept && (s_func == FUNC_LOAD) && in_range;
    assign ram_addr       = s_symbol[ADDR_W-1:0];
    assign ram_wdata.len  = len_cl;
    assign ram_wdata.code = s_code_bits & len_mask;

    assign s1_valid_next = accept && ((s_func == FUNC_FLUSH)
                                   || ((s_func == FUNC_ENCODE) && in_range));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_flush_reg <= (s_func == FUNC_FLUSH);
    end

    // drop absent codes here so the packer sees only real work
    always_comb begin
        q_push       = s1_valid_reg && (s1_flush_reg || (ram_rdata.len != '0));
        q_op.flush   = s1_flush_reg;
        q_op.len     = s1_flush_reg ? '0 : ram_rdata.len;
        q_op.code_al = s1_flush_reg ? '0
                     : ram_rdata.code << (LEN_W'(CODE_W) - ram_rdata.len);
    end

endmodule

@@ sv/hbp_back.sv @@
module hbp_back import hbp_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               q_valid,
    input  hbp_op_t            q_op,
    output logic               q_pop,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last,
    output logic [TOTAL_W-1:0] m_total_bits
);

    logic [BYTE_W-1:0]  pend_reg, pend_next;
    logic [PCNT_W-1:0]  pcnt_reg, pcnt_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               busy_reg, busy_next;
    logic [ACC_W-1:0]   work_reg, work_next;
    logic [CNT_W-1:0]   wcnt_reg, wcnt_next;
    logic               m_valid_reg, m_valid_next;
    logic [7:0]         m_byte_reg, m_byte_next;
    logic               m_last_reg, m_last_next;
    logic [TOTAL_W-1:0] m_total_reg, m_total_next;

    logic               can_out;
    logic               emit;
    logic [ACC_W-1:0]   merged;
    logic [CNT_W-1:0]   mcnt;
    logic [TOTAL_W-1:0] add_total;

    assign can_out   = !m_valid_reg || m_ready;
    // pending bits sit left aligned; append the new code right behind them
    assign merged    = {pend_reg, {CODE_W{1'b0}}} | ({q_op.code_al, {BYTE_W{1'b0}}} >> pcnt_reg);
    assign mcnt      = CNT_W'(pcnt_reg) + CNT_W'(q_op.len);
    assign add_total = total_reg + TOTAL_W'(q_op.len);

    always_comb begin
        pend_next    = pend_reg;
        pcnt_next    = pcnt_reg;
        total_next   = total_reg;
        busy_next    = busy_reg;
        work_next    = work_reg;
        wcnt_next    = wcnt_reg;
        q_pop        = 1'b0;
        emit         = 1'b0;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_total_next = m_total_reg;

        if (busy_reg) begin
            if (can_out) begin
                emit         = 1'b1;
                m_byte_next  = work_reg[ACC_W-1 -: BYTE_W];
                m_last_next  = (wcnt_reg < CNT_W'(2 * BYTE_W));
                m_total_next = total_reg;
                work_next    = work_reg << BYTE_W;
                wcnt_next    = wcnt_reg - CNT_W'(BYTE_W);
                if (wcnt_reg < CNT_W'(2 * BYTE_W)) begin
                    busy_next = 1'b0;
                    pend_next = work_reg[ACC_W-BYTE_W-1 -: BYTE_W];
                    pcnt_next = PCNT_W'(wcnt_reg - CNT_W'(BYTE_W));
                end
            end
        end else if (q_valid) begin
            if (q_op.flush) begin
                if (can_out) begin
                    q_pop        = 1'b1;
                    emit         = 1'b1;
                    m_byte_next  = pend_reg;
                    m_last_next  = 1'b1;
                    m_total_next = total_reg;
                    pend_next    = '0;
                    pcnt_next    = '0;
                    total_next   = '0;
                end
            end else if (mcnt < CNT_W'(BYTE_W)) begin
                // no byte completes: just absorb the bits
                q_pop      = 1'b1;
                pend_next  = merged[ACC_W-1 -: BYTE_W];
                pcnt_next  = PCNT_W'(mcnt);
                total_next = add_total;
            end else if (can_out) begin
                q_pop        = 1'b1;
                emit         = 1'b1;
                m_byte_next  = merged[ACC_W-1 -: BYTE_W];
                m_last_next  = (mcnt < CNT_W'(2 * BYTE_W));
                m_total_next = add_total;
                total_next   = add_total;
                if (mcnt < CNT_W'(2 * BYTE_W)) begin
                    pend_next = merged[ACC_W-BYTE_W-1 -: BYTE_W];
                    pcnt_next = PCNT_W'(mcnt - CNT_W'(BYTE_W));
                end else begin
                    busy_next = 1'b1;
                    work_next = merged << BYTE_W;
                    wcnt_next = mcnt - CNT_W'(BYTE_W);
                end
            end
        end

        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= '0;
            pcnt_reg    <= '0;
            total_reg   <= '0;
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            pend_reg    <= pend_next;
            pcnt_reg    <= pcnt_next;
            total_reg   <= total_next;
            busy_reg    <= busy_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg    <= work_next;
        wcnt_reg    <= wcnt_next;
        m_byte_reg  <= m_byte_next;
        m_last_reg  <= m_last_next;
        m_total_reg <= m_total_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_out_byte   = m_byte_reg;
    assign m_last       = m_last_reg;
    assign m_total_bits = m_total_reg;

endmodule

@@ sv/huffman_table_bit_packer.sv @@
// Table-driven Huffman encoder and bit packer. Load words (func 0) write one
// code table entry and give no result; encode words (func 1) look the byte up
// and append its code first bit first, giving one result per completed byte
// (none for an absent code); a flush word (func 2) gives the zero-padded last
// byte with the stream's bit count and starts a new stream. One input word is
// taken per cycle while s_ready is high; the table lookup is one registered
// RAM read, and looked-up codes wait in a four-entry queue ahead of the
// packer. The packer gives one output byte per cycle while its output is not
// stalled, so an encode that completes k bytes (k up to 4) holds the packer
// until all k are given; s_ready falls only when that queue, counting a lookup
// still in flight, is full. A word's bytes pass the RAM read, queue and output.
module huffman_table_bit_packer import hbp_pkg::*; #(
    parameter int MAX_CODE_LEN = 32,
    parameter int SYMBOLS      = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic [7:0]         s_symbol,
    input  logic [CODE_W-1:0]  s_code_bits,
    input  logic [LEN_W-1:0]   s_code_length,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [7:0]         m_out_byte,
    output logic               m_last,
    output logic [TOTAL_W-1:0] m_total_bits
);

    localparam int ADDR_W = (SYMBOLS > 1) ? $clog2(SYMBOLS) : 1;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_addr;
    hbp_entry_t        ram_wdata;
    hbp_entry_t        ram_rdata;
    logic              q_push;
    logic              q_pop;
    logic              q_valid;
    hbp_op_t           q_op_in;
    hbp_op_t           q_op_out;
    logic [QCNT_W-1:0] q_count;

    hbp_front #(
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .SYMBOLS      (SYMBOLS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_func        (s_func),
        .s_symbol      (s_symbol),
        .s_code_bits   (s_code_bits),
        .s_code_length (s_code_length),
        .q_count       (q_count),
        .q_push        (q_push),
        .q_op          (q_op_in),
        .ram_we        (ram_we),
        .ram_addr      (ram_addr),
        .ram_wdata     (ram_wdata),
        .ram_rdata     (ram_rdata)
    );

    hbp_ram #(
        .WIDTH ($bits(hbp_entry_t)),
        .DEPTH (SYMBOLS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    hbp_fifo u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .op_in     (q_op_in),
        .pop       (q_pop),
        .op_out    (q_op_out),
        .not_empty (q_valid),
        .count     (q_count)
    );

    hbp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_op         (q_op_out),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_last       (m_last),
        .m_total_bits (m_total_bits)
    );

endmodule

@@ sv/hbp_checker.sv @@
module hbp_checker import hbp_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic [1:0]         s_func,
    input logic [7:0]         s_symbol,
    input logic [CODE_W-1:0]  s_code_bits,
    input logic [LEN_W-1:0]   s_code_length,
    input logic               m_valid,
    input logic               m_ready,
    input logic [7:0]         m_out_byte,
    input logic               m_last,
    input logic [TOTAL_W-1:0] m_total_bits
);

    logic               chain_reg;
    logic [TOTAL_W-1:0] chain_total_reg;

    // track whether the next result belongs to the same input item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chain_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            chain_reg <= !m_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid && m_ready) begin
            chain_total_reg <= m_total_bits;
        end
    end

    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_func) && $stable(s_symbol)
                               && $stable(s_code_bits) && $stable(s_code_length))
        else $error("waiting input word changed");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte)
                               && $stable(m_last) && $stable(m_total_bits))
        else $error("stalled result changed");

    a_burst_total: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && chain_reg |-> m_total_bits == chain_total_reg)
        else $error("bit count changed within one item's results");

    a_burst_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("gap inside one item's results");

endmodule

bind huffman_table_bit_packer hbp_checker u_hbp_checker (.*);
